/* src/assert_macros.svh */
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property check on the rising clock edge, off while reset is held low.
`define SAWC_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("cache port check failed");

// Same-cycle implication check.
`define SAWC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cache port implication failed");

`endif

/* src/sawc_pkg.sv */
// ----------------------------------------------------------------------------
// sawc_pkg
// Shared constants, codes and types of the set-associative write-back cache.
// ----------------------------------------------------------------------------
package sawc_pkg;

  localparam int BLOCK_OFFSET_BITS = 6;
  localparam int ADDR_BITS         = 25;
  localparam int WORD_BITS         = BLOCK_OFFSET_BITS - 2;
  localparam int WORDS             = 1 << WORD_BITS;
  localparam int BLK_BITS          = ADDR_BITS - BLOCK_OFFSET_BITS;

  localparam int DEF_MAX_SETS = 64;
  localparam int DEF_MAX_WAYS = 4;

  // input opcodes
  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_FILL  = 2'd2;
  localparam logic [1:0] OP_NONE  = 2'd3;

  // result kinds
  localparam logic [2:0] KIND_READ   = 3'd0;
  localparam logic [2:0] KIND_WRITE  = 3'd1;
  localparam logic [2:0] KIND_WB     = 3'd2;
  localparam logic [2:0] KIND_FREQ   = 3'd3;
  localparam logic [2:0] KIND_UNEXP  = 3'd4;
  localparam logic [2:0] KIND_REJECT = 3'd5;

  // configuration register indexes
  localparam logic [1:0] CFG_SET_BITS = 2'd0;
  localparam logic [1:0] CFG_WAY_BITS = 2'd1;
  localparam logic [1:0] CFG_SEED     = 2'd2;

  localparam logic [2:0]  RST_SET_BITS = 3'd6;
  localparam logic [1:0]  RST_WAY_BITS = 2'd2;
  localparam logic [15:0] RST_SEED     = 16'd44257;
  localparam logic [15:0] LFSR_TAPS    = 16'hB400;

  // control from the sequencer to the victim picker
  typedef struct packed {
    logic        load;
    logic [15:0] seed;
    logic        pick;
  } lfsr_ctl_t;

endpackage

/* src/set_assoc_writeback_cache.sv */
// ----------------------------------------------------------------------------
// set_assoc_writeback_cache
// Set-associative write-back, write-allocate cache with random replacement.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  in_     | in  | in_tvalid/tready   | tuser opcode, tdata address..fill_data
//  out_    | out | out_tvalid/tready  | tuser kind,was_hit, tdata, tlast last
//  cfg_    | in  | cfg_valid/ready    | cfg_index, cfg_data
//
//  A hit passes through accept, tag row read, data word access and result.
//  A miss reads and then emits each writeback word in turn (one data memory
//  read port), then emits the fill request; fill words are stored as they
//  arrive and the last one is followed by a read back of the requested word.
//  Reset clears control state and the valid/dirty flops; no clearing pass.
//  A result waits in the output register; while that register is still
//  full, the sequencer stalls when a new result is due and takes no input.
module set_assoc_writeback_cache #(
  parameter int MAX_SETS = sawc_pkg::DEF_MAX_SETS,
  parameter int MAX_WAYS = sawc_pkg::DEF_MAX_WAYS
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // address[24:0] wdata[56:25] wmask[88:57] fdata[120:89]
  input  logic [1:0]   in_tuser,   // opcode[1:0]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [55:0]  out_tdata,  // data[31:0] memory_block[50:32] word_index[54:51]
  output logic [3:0]   out_tuser,  // kind[2:0] was_hit[3]
  output logic         out_tlast,  // last
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [15:0]  cfg_data
);
  import sawc_pkg::*;

  localparam int SETW  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int WAYW  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int LINES = MAX_SETS * MAX_WAYS;
  localparam int LINEW = (LINES > 1) ? $clog2(LINES) : 1;
  localparam int DADW  = LINEW + WORD_BITS;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_TAG    = 3'd1;
  localparam logic [2:0] S_DATA   = 3'd2;
  localparam logic [2:0] S_WB_RD  = 3'd3;
  localparam logic [2:0] S_WB_EM  = 3'd4;
  localparam logic [2:0] S_FREQ   = 3'd5;
  localparam logic [2:0] S_FIN_RD = 3'd6;
  localparam logic [2:0] S_FIN_EM = 3'd7;

  // input word fields
  logic [1:0]            in_op;
  logic [ADDR_BITS-1:0]  in_addr;
  logic [31:0]           in_wdata, in_wmask, in_fdata;
  assign in_op    = in_tuser;
  assign in_addr  = in_tdata[24:0];
  assign in_wdata = in_tdata[56:25];
  assign in_wmask = in_tdata[88:57];
  assign in_fdata = in_tdata[120:89];

  // configuration
  logic [2:0] set_bits_r;
  logic [1:0] way_bits_r;
  lfsr_ctl_t  lctl;
  logic       cfg_fire;
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_bits_r <= RST_SET_BITS;
      way_bits_r <= RST_WAY_BITS;
    end else if (cfg_fire) begin
      case (cfg_index)
        CFG_SET_BITS: set_bits_r <= cfg_data[2:0];
        CFG_WAY_BITS: way_bits_r <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // sequencer registers
  logic [2:0]           state_r, state_nxt;
  logic                 acc_wr_r, acc_wr_nxt;
  logic [BLK_BITS-1:0]  acc_blk_r, acc_blk_nxt;
  logic [WORD_BITS-1:0] acc_word_r, acc_word_nxt;
  logic [31:0]          acc_wdata_r, acc_wdata_nxt, acc_wmask_r, acc_wmask_nxt;
  logic [SETW-1:0]      acc_set_r, acc_set_nxt;
  logic [WAYW-1:0]      line_way_r, line_way_nxt;
  logic [BLK_BITS-1:0]  vic_tag_r, vic_tag_nxt;
  logic [WORD_BITS-1:0] wb_cnt_r, wb_cnt_nxt, fill_cnt_r, fill_cnt_nxt;
  logic                 pend_on_r, pend_on_nxt;

  // output register
  logic                 out_valid_r;
  logic [2:0]           out_kind_r;
  logic [31:0]          out_data_r;
  logic [BLK_BITS-1:0]  out_blk_r;
  logic [WORD_BITS-1:0] out_widx_r;
  logic                 out_hit_r, out_last_r;
  logic                 emit, e_hit, e_last;
  logic [2:0]           e_kind;
  logic [31:0]          e_data;
  logic [BLK_BITS-1:0]  e_blk;
  logic [WORD_BITS-1:0] e_widx;
  logic                 ofree;

  // memories
  logic [BLK_BITS-1:0]  tag_mem [MAX_SETS][MAX_WAYS];
  logic [BLK_BITS-1:0]  tag_q_r [MAX_WAYS];
  logic                 tag_re, tag_we;
  logic [SETW-1:0]      tag_rset;
  logic [31:0]          data_mem [LINES*WORDS];
  logic [31:0]          dm_q_r;
  logic                 dm_re, dm_we;
  logic [DADW-1:0]      dm_raddr, dm_waddr;
  logic [31:0]          dm_wdata;

  // valid and dirty flags, one row of ways per set, read beside the tag row
  logic [MAX_WAYS-1:0]  valid_r [MAX_SETS];
  logic [MAX_WAYS-1:0]  dirty_r [MAX_SETS];
  logic [MAX_WAYS-1:0]  valid_q_r, dirty_q_r;
  logic                 vd_clr, vd_fill, vd_dirty;

  // access decode
  logic                 in_fire;
  logic [BLK_BITS-1:0]  in_blk;
  logic [SETW-1:0]      in_set;
  logic [7:0]           s2;
  logic [4:0]           w2, wcount;
  logic [MAX_WAYS-1:0]  way_hit, row_free;
  logic                 hit;
  logic [WAYW-1:0]      hit_way, victim_way;
  logic [LINEW-1:0]     line_idx;
  logic [31:0]          merged;

  assign ofree     = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE) && ofree;
  assign in_fire   = in_tvalid && in_tready;
  assign in_blk    = in_addr[ADDR_BITS-1:BLOCK_OFFSET_BITS];
  assign line_idx  = LINEW'(int'(acc_set_r) * MAX_WAYS + int'(line_way_r));
  assign merged    = (dm_q_r & ~acc_wmask_r) | (acc_wdata_r & acc_wmask_r);

  always_comb begin
    s2 = 8'd1 << set_bits_r;
    if (int'(s2) <= MAX_SETS) begin
      in_set = SETW'(in_blk & (BLK_BITS'(s2) - BLK_BITS'(1)));
    end else begin
      in_set = SETW'(in_blk % MAX_SETS);
    end
    w2 = 5'd1 << way_bits_r;
    wcount = (int'(w2) > MAX_WAYS) ? 5'(MAX_WAYS) : w2;
    // search the ways in use of the addressed set
    hit = 1'b0;
    hit_way = '0;
    for (int i = 0; i < MAX_WAYS; i++) begin
      logic in_use;
      in_use = i < int'(wcount);
      way_hit[i]  = in_use && valid_q_r[i] && (tag_q_r[i] == acc_blk_r);
      row_free[i] = in_use && !valid_q_r[i];
    end
    for (int i = MAX_WAYS - 1; i >= 0; i--) begin
      if (way_hit[i]) begin
        hit = 1'b1;
        hit_way = WAYW'(i);
      end
    end
  end

  sawc_victim #(
    .MAX_WAYS (MAX_WAYS),
    .WAYW     (WAYW)
  ) u_victim (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (lctl),
    .way_bits   (way_bits_r),
    .row_free   (row_free),
    .victim_way (victim_way)
  );

  always_comb begin
    state_nxt     = state_r;
    acc_wr_nxt    = acc_wr_r;
    acc_blk_nxt   = acc_blk_r;
    acc_word_nxt  = acc_word_r;
    acc_wdata_nxt = acc_wdata_r;
    acc_wmask_nxt = acc_wmask_r;
    acc_set_nxt   = acc_set_r;
    line_way_nxt  = line_way_r;
    vic_tag_nxt   = vic_tag_r;
    wb_cnt_nxt    = wb_cnt_r;
    fill_cnt_nxt  = fill_cnt_r;
    pend_on_nxt   = pend_on_r;
    emit = 1'b0; e_kind = KIND_READ; e_data = '0; e_blk = '0; e_widx = '0;
    e_hit = 1'b0; e_last = 1'b1;
    tag_re = 1'b0; tag_rset = in_set; tag_we = 1'b0;
    dm_re = 1'b0; dm_raddr = {line_idx, acc_word_r};
    dm_we = 1'b0; dm_waddr = {line_idx, acc_word_r}; dm_wdata = merged;
    vd_clr = 1'b0; vd_fill = 1'b0; vd_dirty = 1'b0;
    lctl.load = cfg_fire && (cfg_index == CFG_SEED);
    lctl.seed = cfg_data;
    lctl.pick = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_fire && in_op != OP_NONE) begin
          if (pend_on_r) begin
            if (in_op != OP_FILL) begin
              emit = 1'b1; e_kind = KIND_REJECT;
            end else begin
              // store the next refill word; the last one validates the line
              dm_we = 1'b1;
              dm_waddr = {line_idx, fill_cnt_r};
              dm_wdata = in_fdata;
              fill_cnt_nxt = fill_cnt_r + 1'b1;
              if (fill_cnt_r == WORD_BITS'(WORDS - 1)) begin
                pend_on_nxt = 1'b0;
                tag_we = 1'b1;
                vd_fill = 1'b1;
                state_nxt = S_FIN_RD;
              end
            end
          end else if (in_op == OP_FILL) begin
            emit = 1'b1; e_kind = KIND_UNEXP;
          end else begin
            acc_wr_nxt    = (in_op == OP_WRITE);
            acc_blk_nxt   = in_blk;
            acc_word_nxt  = in_addr[BLOCK_OFFSET_BITS-1:2];
            acc_wdata_nxt = in_wdata;
            acc_wmask_nxt = in_wmask;
            acc_set_nxt   = in_set;
            tag_re = 1'b1;
            state_nxt = S_TAG;
          end
        end
      end
      S_TAG: begin
        if (hit) begin
          line_way_nxt = hit_way;
          dm_re = 1'b1;
          dm_raddr = {LINEW'(int'(acc_set_r) * MAX_WAYS + int'(hit_way)), acc_word_r};
          state_nxt = S_DATA;
        end else begin
          lctl.pick = 1'b1;
          line_way_nxt = victim_way;
          vic_tag_nxt = tag_q_r[victim_way];
          wb_cnt_nxt = '0;
          vd_clr = 1'b1;
          state_nxt = (valid_q_r[victim_way] && dirty_q_r[victim_way]) ? S_WB_RD : S_FREQ;
        end
      end
      S_DATA, S_FIN_EM: begin
        if (ofree) begin
          emit = 1'b1;
          e_hit = (state_r == S_DATA);
          if (acc_wr_r) begin
            dm_we = 1'b1;
            vd_dirty = 1'b1;
            e_kind = KIND_WRITE;
          end else begin
            e_kind = KIND_READ;
            e_data = dm_q_r;
          end
          state_nxt = S_IDLE;
        end
      end
      S_WB_RD: begin
        dm_re = 1'b1;
        dm_raddr = {line_idx, wb_cnt_r};
        state_nxt = S_WB_EM;
      end
      S_WB_EM: begin
        if (ofree) begin
          emit = 1'b1; e_kind = KIND_WB; e_data = dm_q_r; e_blk = vic_tag_r;
          e_widx = wb_cnt_r; e_last = 1'b0;
          wb_cnt_nxt = wb_cnt_r + 1'b1;
          state_nxt = (wb_cnt_r == WORD_BITS'(WORDS - 1)) ? S_FREQ : S_WB_RD;
        end
      end
      S_FREQ: begin
        if (ofree) begin
          emit = 1'b1; e_kind = KIND_FREQ; e_blk = acc_blk_r;
          pend_on_nxt = 1'b1;
          fill_cnt_nxt = '0;
          state_nxt = S_IDLE;
        end
      end
      S_FIN_RD: begin
        dm_re = 1'b1;
        state_nxt = S_FIN_EM;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pend_on_r   <= 1'b0;
      fill_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      pend_on_r  <= pend_on_nxt;
      fill_cnt_r <= fill_cnt_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    acc_wr_r    <= acc_wr_nxt;
    acc_blk_r   <= acc_blk_nxt;
    acc_word_r  <= acc_word_nxt;
    acc_wdata_r <= acc_wdata_nxt;
    acc_wmask_r <= acc_wmask_nxt;
    acc_set_r   <= acc_set_nxt;
    line_way_r  <= line_way_nxt;
    vic_tag_r   <= vic_tag_nxt;
    wb_cnt_r    <= wb_cnt_nxt;
    if (emit) begin
      out_kind_r <= e_kind;
      out_data_r <= e_data;
      out_blk_r  <= e_blk;
      out_widx_r <= e_widx;
      out_hit_r  <= e_hit;
      out_last_r <= e_last;
    end
  end

  // flag rows: one way of the current set changes per cycle at most
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_SETS; i++) begin
        valid_r[i] <= '0;
        dirty_r[i] <= '0;
      end
    end else begin
      if (vd_clr) begin
        valid_r[acc_set_r][victim_way] <= 1'b0;
        dirty_r[acc_set_r][victim_way] <= 1'b0;
      end
      if (vd_fill) begin
        valid_r[acc_set_r][line_way_r] <= 1'b1;
        dirty_r[acc_set_r][line_way_r] <= 1'b0;
      end
      if (vd_dirty) begin
        dirty_r[acc_set_r][line_way_r] <= 1'b1;
      end
    end
  end

  // tag memory: one row per set, written one way at a time
  always_ff @(posedge clk) begin
    if (tag_we) begin
      tag_mem[acc_set_r][line_way_r] <= acc_blk_r;
    end
    if (tag_re) begin
      for (int i = 0; i < MAX_WAYS; i++) begin
        tag_q_r[i] <= tag_mem[tag_rset][i];
      end
      valid_q_r <= valid_r[tag_rset];
      dirty_q_r <= dirty_r[tag_rset];
    end
  end

  // data memory: one write and one read port
  always_ff @(posedge clk) begin
    if (dm_we) begin
      data_mem[dm_waddr] <= dm_wdata;
    end
    if (dm_re) begin
      dm_q_r <= data_mem[dm_raddr];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_widx_r, out_blk_r, out_data_r};
  assign out_tuser  = {out_hit_r, out_kind_r};
  assign out_tlast  = out_last_r;

endmodule

/* src/sawc_victim.sv */
// ----------------------------------------------------------------------------
// sawc_victim
// Victim way choice: lowest free way, else a Galois LFSR pick over the ways.
// ----------------------------------------------------------------------------
module sawc_victim #(
  parameter int MAX_WAYS = sawc_pkg::DEF_MAX_WAYS,
  parameter int WAYW     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  sawc_pkg::lfsr_ctl_t ctl,
  input  logic [1:0]          way_bits,
  input  logic [MAX_WAYS-1:0] row_free,
  output logic [WAYW-1:0]     victim_way
);
  import sawc_pkg::*;

  logic [15:0] lfsr_r, lfsr_nxt, lfsr_step;
  logic [3:0]  w2;
  logic [WAYW-1:0] rnd_way, free_way;
  logic        any_free;

  always_comb begin
    lfsr_step = (lfsr_r >> 1) ^ (lfsr_r[0] ? LFSR_TAPS : 16'd0);
    w2 = 4'd1 << way_bits;
    if (int'(w2) <= MAX_WAYS) begin
      rnd_way = WAYW'(lfsr_step & (16'(w2) - 16'd1));
    end else begin
      rnd_way = WAYW'(lfsr_step % MAX_WAYS);
    end
    any_free = 1'b0;
    free_way = '0;
    for (int i = MAX_WAYS - 1; i >= 0; i--) begin
      if (row_free[i]) begin
        any_free = 1'b1;
        free_way = WAYW'(i);
      end
    end
    victim_way = any_free ? free_way : rnd_way;
    lfsr_nxt = lfsr_r;
    if (ctl.load) begin
      lfsr_nxt = (ctl.seed != 16'd0) ? ctl.seed : 16'd1;
    end else if (ctl.pick && !any_free) begin
      lfsr_nxt = lfsr_step;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lfsr_r <= RST_SEED;
    end else begin
      lfsr_r <= lfsr_nxt;
    end
  end

endmodule

/* src/sawc_checker.sv */
// ----------------------------------------------------------------------------
// sawc_checker
// Port-level checks of the cache result stream.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sawc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [55:0] out_tdata,
  input logic [3:0]  out_tuser,
  input logic        out_tlast
);
  import sawc_pkg::*;

  // hold a stalled result word
  `SAWC_ASSERT(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
  // writeback words never close an item
  `SAWC_ASSERT_IMP(a_wb_not_last, clk, rst_n, out_tvalid && out_tuser[2:0] == KIND_WB, !out_tlast)
  // every other kind is the only or final result
  `SAWC_ASSERT_IMP(a_other_last, clk, rst_n, out_tvalid && out_tuser[2:0] != KIND_WB, out_tlast)
  // a hit flag only on completed reads and writes
  `SAWC_ASSERT_IMP(a_hit_kind, clk, rst_n, out_tvalid && out_tuser[3], out_tuser[2:0] == KIND_READ || out_tuser[2:0] == KIND_WRITE)

endmodule

bind set_assoc_writeback_cache sawc_checker u_sawc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
